// ===== sv/tlb_pkg.sv =====
// shared types and constants for the tlb translate block
`timescale 1ns / 1ps
package tlb_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_SCAN,
    ST_EVICT,
    ST_FILL,
    ST_DONE
  } tlb_state_t;

  typedef struct packed {
    logic start;
    logic lookup;
    logic scan_clear;
    logic scan_step;
    logic evict;
    logic fill;
  } tlb_cmd_t;

  typedef struct packed {
    logic hit;
    logic resident;
    logic free_avail;
    logic scan_last;
  } tlb_status_t;

  localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

endpackage

// ===== sv/tlb_if.sv =====
// valid/ready channel interface
`timescale 1ns / 1ps
interface tlb_if #(
  parameter int W = 12
) ();
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/tlb_page_table_lru_translate.sv =====
// top level of the demand-paged tlb translate block
`timescale 1ns / 1ps
// Translates one 12-bit virtual address per beat through a fully associative
// TLB backed by a page table with LRU replacement. A TLB hit, a page-table
// hit or a fault into a free frame goes through the lookup, fill and done
// states; after lookup, a page fault once all frames are in use runs the LRU stamp
// scan, one page per cycle, and an evict state before the fill. One item is handled
// at a time; the next is taken in the cycle after the result beat has been
// delivered.
module tlb_page_table_lru_translate import tlb_pkg::*; #(
  parameter int PAGES = 16,
  parameter int FRAMES = 8,
  parameter int TLB_ENTRIES = 4,
  parameter int PAGE_SIZE = 256
) (
  input  logic clk,
  input  logic rst,
  tlb_if.sink  in_ch,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [10:0] physical_address,
  output logic        tlb_hit,
  output logic        page_fault,
  output logic        evicted_valid,
  output logic [3:0]  evicted_page,
  output logic [31:0] hit_total,
  output logic [31:0] miss_total,
  output logic [31:0] fault_total
);

  tlb_cmd_t    cmd;
  tlb_status_t status;

  tlb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  tlb_dp #(
    .PAGES       (PAGES),
    .FRAMES      (FRAMES),
    .TLB_ENTRIES (TLB_ENTRIES),
    .PAGE_SIZE   (PAGE_SIZE)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .va               (in_ch.data),
    .cmd              (cmd),
    .status           (status),
    .physical_address (physical_address),
    .tlb_hit          (tlb_hit),
    .page_fault       (page_fault),
    .evicted_valid    (evicted_valid),
    .evicted_page     (evicted_page),
    .hit_total        (hit_total),
    .miss_total       (miss_total),
    .fault_total      (fault_total)
  );

endmodule

// ===== sv/tlb_ctrl.sv =====
// translate controller state machine
`timescale 1ns / 1ps
module tlb_ctrl import tlb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  tlb_status_t status,
  output tlb_cmd_t    cmd
);

  tlb_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_valid) state_next = ST_LOOKUP;
      ST_LOOKUP: begin
        if (status.hit || status.resident || status.free_avail) state_next = ST_FILL;
        else state_next = ST_SCAN;
      end
      ST_SCAN:   if (status.scan_last) state_next = ST_EVICT;
      ST_EVICT:  state_next = ST_FILL;
      ST_FILL:   state_next = ST_DONE;
      ST_DONE:   if (out_ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.start = in_valid;
      end
      ST_LOOKUP: begin
        cmd.lookup = 1'b1;
        cmd.scan_clear = 1'b1;
      end
      ST_SCAN:  cmd.scan_step = 1'b1;
      ST_EVICT: cmd.evict = 1'b1;
      ST_FILL:  cmd.fill = 1'b1;
      ST_DONE:  out_valid = 1'b1;
      default: ;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst) out_valid |-> !in_ready)
    else $error("accepting while result pending");
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_EVICT) |-> $past(state) == ST_SCAN)
    else $error("evict without scan");
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && !out_ready) |=> state == ST_DONE)
    else $error("result dropped");

endmodule

// ===== sv/tlb_dp.sv =====
// translate datapath: tlb, page table, lru scan and counters
`timescale 1ns / 1ps
module tlb_dp import tlb_pkg::*; #(
  parameter int PAGES = 16,
  parameter int FRAMES = 8,
  parameter int TLB_ENTRIES = 4,
  parameter int PAGE_SIZE = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [11:0] va,
  input  tlb_cmd_t    cmd,
  output tlb_status_t status,
  output logic [10:0] physical_address,
  output logic        tlb_hit,
  output logic        page_fault,
  output logic        evicted_valid,
  output logic [3:0]  evicted_page,
  output logic [31:0] hit_total,
  output logic [31:0] miss_total,
  output logic [31:0] fault_total
);

  localparam int PW = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int FW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int TW = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
  localparam int OW = $clog2(PAGE_SIZE);
  localparam int CW = $clog2(FRAMES + 1);

  logic [TLB_ENTRIES-1:0] tv;
  logic [PW-1:0]          tpage [TLB_ENTRIES];
  logic [FW-1:0]          tframe[TLB_ENTRIES];
  logic [32:0]            tstamp[TLB_ENTRIES];
  logic [PAGES-1:0]       pres;
  logic [FW-1:0]          pframe[PAGES];
  logic [31:0]            pstamp[PAGES];
  logic [CW-1:0]          nfree;
  logic [31:0]            rtime;

  logic [PW-1:0]  page;
  logic [OW-1:0]  offset;
  logic [FW-1:0]  frame;
  logic [PW-1:0]  scan_idx, victim;
  logic [31:0]    best;
  logic           found;
  logic           hit_r;
  logic [TW-1:0]  hit_slot;

  logic           hit_c;
  logic [TW-1:0]  hit_slot_c;
  logic [TW-1:0]  fill_slot;
  logic [31:0]    rtime_inc;

  assign rtime_inc = (rtime == SAT32) ? rtime : rtime + 32'd1;

  always_comb begin
    hit_c = 1'b0;
    hit_slot_c = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if (tv[i] && tpage[i] == page) begin
        hit_c = 1'b1;
        hit_slot_c = TW'(i);
      end
    end
  end

  always_comb begin
    fill_slot = '0;
    for (int i = 1; i < TLB_ENTRIES; i++) begin
      if ($signed(tstamp[i]) < $signed(tstamp[fill_slot])) fill_slot = TW'(i);
    end
  end

  assign status.hit = hit_c;
  assign status.resident = pres[page];
  assign status.free_avail = nfree < CW'(FRAMES);
  assign status.scan_last = scan_idx == PW'(PAGES - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      tv <= '0;
      pres <= '0;
      nfree <= '0;
      rtime <= '0;
      hit_total <= '0;
      miss_total <= '0;
      fault_total <= '0;
      physical_address <= '0;
      tlb_hit <= 1'b0;
      page_fault <= 1'b0;
      evicted_valid <= 1'b0;
      evicted_page <= '0;
      for (int i = 0; i < TLB_ENTRIES; i++) tstamp[i] <= '1;
      for (int i = 0; i < PAGES; i++) pstamp[i] <= '0;
    end else begin
      if (cmd.start) begin
        page <= PW'((va / PAGE_SIZE) % PAGES);
        offset <= OW'(va % PAGE_SIZE);
        rtime <= rtime_inc;
        page_fault <= 1'b0;
        evicted_valid <= 1'b0;
        evicted_page <= '0;
      end
      if (cmd.scan_clear) begin
        scan_idx <= '0;
        found <= 1'b0;
      end
      if (cmd.lookup) begin
        hit_r <= hit_c;
        hit_slot <= hit_slot_c;
        if (hit_c) begin
          hit_total <= (hit_total == SAT32) ? hit_total : hit_total + 32'd1;
          frame <= tframe[hit_slot_c];
        end else begin
          miss_total <= (miss_total == SAT32) ? miss_total : miss_total + 32'd1;
          if (pres[page]) frame <= pframe[page];
          else begin
            page_fault <= 1'b1;
            fault_total <= (fault_total == SAT32) ? fault_total : fault_total + 32'd1;
            if (nfree < CW'(FRAMES)) begin
              frame <= FW'(nfree);
              nfree <= nfree + CW'(1);
            end
          end
        end
      end
      if (cmd.scan_step) begin
        if (pres[scan_idx] && (!found || pstamp[scan_idx] < best)) begin
          found <= 1'b1;
          best <= pstamp[scan_idx];
          victim <= scan_idx;
        end
        if (scan_idx != PW'(PAGES - 1)) scan_idx <= scan_idx + PW'(1);
      end
      if (cmd.evict && found) begin
        evicted_valid <= 1'b1;
        evicted_page <= 4'(victim);
        frame <= pframe[victim];
        pres[victim] <= 1'b0;
        for (int i = 0; i < TLB_ENTRIES; i++) begin
          if (tv[i] && tpage[i] == victim) begin
            tv[i] <= 1'b0;
            tstamp[i] <= '1;
          end
        end
      end
      if (cmd.fill) begin
        tlb_hit <= hit_r;
        physical_address <= 11'({frame, offset});
        pstamp[page] <= rtime;
        if (hit_r) begin
          tstamp[hit_slot] <= {1'b0, rtime};
        end else begin
          if (page_fault) begin
            pres[page] <= 1'b1;
            pframe[page] <= frame;
          end
          tv[fill_slot] <= 1'b1;
          tpage[fill_slot] <= page;
          tframe[fill_slot] <= frame;
          tstamp[fill_slot] <= {1'b0, rtime};
        end
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) evicted_valid |-> page_fault)
    else $error("eviction without fault");
  assert property (@(posedge clk) disable iff (rst) cmd.fill && hit_r |-> !page_fault)
    else $error("hit with fault");
  assert property (@(posedge clk) disable iff (rst) nfree <= CW'(FRAMES))
    else $error("free frame count overflow");

endmodule

// ===== sim/tb_tlb_page_table_lru_translate.sv =====
// testbench for tlb_page_table_lru_translate: scoreboard against an in-bench translation model
`timescale 1ns / 1ps
module tb_tlb_page_table_lru_translate import tlb_pkg::*; ();

  localparam int NPAGES = 16;
  localparam int NFRAMES = 8;
  localparam int NSLOTS = 4;
  localparam int RANDOM_ITEMS = 1330;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [10:0] pa;
    logic        hit;
    logic        fault;
    logic        ev_valid;
    logic [3:0]  ev_page;
    logic [31:0] hits;
    logic [31:0] misses;
    logic [31:0] faults;
  } xlate_t;

  logic clk = 0;
  logic rst = 1;
  logic out_valid, out_ready = 0;
  logic [10:0] physical_address;
  logic tlb_hit, page_fault, evicted_valid;
  logic [3:0] evicted_page;
  logic [31:0] hit_total, miss_total, fault_total;

  tlb_if #(.W(12)) in_ch ();

  tlb_page_table_lru_translate u_dut (
    .clk(clk), .rst(rst), .in_ch(in_ch),
    .out_valid(out_valid), .out_ready(out_ready),
    .physical_address(physical_address), .tlb_hit(tlb_hit), .page_fault(page_fault),
    .evicted_valid(evicted_valid), .evicted_page(evicted_page),
    .hit_total(hit_total), .miss_total(miss_total), .fault_total(fault_total)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // translation model state
  logic        slot_valid [NSLOTS];
  logic [3:0]  slot_page [NSLOTS];
  logic [2:0]  slot_frame [NSLOTS];
  longint      slot_stamp [NSLOTS];
  logic        resident [NPAGES];
  logic [2:0]  page_frame [NPAGES];
  logic [31:0] page_age [NPAGES];
  int          free_frame;
  logic [31:0] now_time, n_hits, n_misses, n_faults;

  logic [11:0] addr_queue [$];
  xlate_t      expected_xlate [$];
  int          n_sent = 0;
  int          n_accepted = 0;
  int          n_checked = 0;
  int          n_errors = 0;
  int          n_tlb_hits = 0;
  int          n_evictions = 0;
  int          cycles = 0;
  logic        in_taken = 0;
  logic        hold_off = 0;
  int          hold_cnt = 0;

  function automatic logic [31:0] sat_add(logic [31:0] v);
    return (v == SAT32) ? v : v + 32'd1;
  endfunction

  function automatic void clear_model();
    for (int i = 0; i < NSLOTS; i++) begin
      slot_valid[i] = 0; slot_page[i] = 0; slot_frame[i] = 0; slot_stamp[i] = -1;
    end
    for (int p = 0; p < NPAGES; p++) begin
      resident[p] = 0; page_frame[p] = 0; page_age[p] = 0;
    end
    free_frame = 0;
    now_time = 0; n_hits = 0; n_misses = 0; n_faults = 0;
  endfunction

  function automatic xlate_t translate(logic [11:0] va);
    xlate_t r;
    logic [3:0] pg;
    logic [2:0] fr;
    logic found;
    logic [31:0] best;
    int victim, slot;
    pg = va[11:8];
    fr = 0;
    r = '0;
    victim = 0;
    slot = 0;
    found = 0;
    best = 0;
    now_time = sat_add(now_time);
    for (int i = 0; i < NSLOTS; i++) begin
      if (!r.hit && slot_valid[i] && slot_page[i] == pg) begin
        r.hit = 1;
        slot_stamp[i] = now_time;
        page_age[pg] = now_time;
        fr = slot_frame[i];
      end
    end
    if (r.hit) begin
      n_hits = sat_add(n_hits);
    end else begin
      n_misses = sat_add(n_misses);
      if (resident[pg]) begin
        fr = page_frame[pg];
      end else begin
        r.fault = 1;
        n_faults = sat_add(n_faults);
        if (free_frame < NFRAMES) begin
          fr = free_frame[2:0];
          free_frame++;
        end else begin
          for (int p = 0; p < NPAGES; p++) begin
            if (resident[p] && (!found || page_age[p] < best)) begin
              found = 1; best = page_age[p]; victim = p;
            end
          end
          if (found) begin
            r.ev_valid = 1;
            r.ev_page = victim[3:0];
            fr = page_frame[victim];
            resident[victim] = 0;
            for (int i = 0; i < NSLOTS; i++) begin
              if (slot_valid[i] && slot_page[i] == victim[3:0]) begin
                slot_valid[i] = 0; slot_stamp[i] = -1;
              end
            end
          end
        end
        resident[pg] = 1;
        page_frame[pg] = fr;
      end
      page_age[pg] = now_time;
      for (int i = 1; i < NSLOTS; i++) begin
        if (slot_stamp[i] < slot_stamp[slot]) slot = i;
      end
      slot_valid[slot] = 1;
      slot_page[slot] = pg;
      slot_frame[slot] = fr;
      slot_stamp[slot] = now_time;
    end
    r.pa = {fr, va[7:0]};
    r.hits = n_hits;
    r.misses = n_misses;
    r.faults = n_faults;
    return r;
  endfunction

  // input beat accepted at the rising edge
  always @(posedge clk) begin
    cycles <= cycles + 1;
    in_taken <= 0;
    if (!rst && in_ch.valid && in_ch.ready) begin
      expected_xlate.push_back(translate(in_ch.data));
      n_accepted <= n_accepted + 1;
      in_taken <= 1;
    end
  end

  // driver
  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 0;
      in_ch.data <= '0;
    end else begin
      if (!in_ch.valid || in_taken) begin
        if (addr_queue.size() > 0 &&
            !((n_sent < 450 && $urandom_range(99) < 24) ||
              (n_sent >= 450 && n_sent < 900 && $urandom_range(99) < 46))) begin
          in_ch.valid <= 1;
          in_ch.data <= addr_queue.pop_front();
          n_sent <= n_sent + 1;
        end else begin
          in_ch.valid <= 0;
        end
      end
    end
  end

  // receiver with one long hold-off
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 0;
    end else if (hold_off) begin
      out_ready <= 0;
      hold_cnt <= hold_cnt + 1;
      if (hold_cnt == 300) hold_off <= 0;
    end else if (n_accepted == 200 && hold_cnt == 0) begin
      hold_off <= 1;
      out_ready <= 0;
    end else if (n_sent < 450) begin
      out_ready <= ($urandom_range(99) >= 46);
    end else if (n_sent < 900) begin
      out_ready <= ($urandom_range(99) >= 24);
    end else begin
      out_ready <= 1;
    end
  end

  // result monitor
  always @(posedge clk) begin
    xlate_t got, want;
    if (!rst && out_valid && out_ready) begin
      got = {physical_address, tlb_hit, page_fault, evicted_valid, evicted_page,
             hit_total, miss_total, fault_total};
      if (expected_xlate.size() == 0) begin
        $display("%0t unexpected beat: actual %h", $time, got);
        n_errors++;
      end else begin
        want = expected_xlate.pop_front();
        if (got != want) begin
          $display("%0t mismatch: expected pa=%h hit=%b flt=%b ev=%b/%h h=%0d m=%0d f=%0d",
                   $time, want.pa, want.hit, want.fault, want.ev_valid, want.ev_page,
                   want.hits, want.misses, want.faults);
          $display("%0t            actual pa=%h hit=%b flt=%b ev=%b/%h h=%0d m=%0d f=%0d",
                   $time, got.pa, got.hit, got.fault, got.ev_valid, got.ev_page,
                   got.hits, got.misses, got.faults);
          n_errors++;
        end
        if (want.hit) n_tlb_hits++;
        if (want.ev_valid) n_evictions++;
        n_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tlb_page_table_lru_translate: mismatch");
      $finish;
    end
  end

  initial begin
    logic [3:0] hot [6];
    clear_model();
    // directed: extremes, free-frame fill, repeats, evictions
    addr_queue.push_back(12'h000);
    addr_queue.push_back(12'hFFF);
    addr_queue.push_back(12'h0FF);
    addr_queue.push_back(12'hF00);
    for (int p = 1; p < 15; p++) addr_queue.push_back({p[3:0], 8'h5A});
    addr_queue.push_back(12'h0A5);
    addr_queue.push_back(12'h0A5);
    addr_queue.push_back(12'hE3C);
    addr_queue.push_back(12'h1C3);
    addr_queue.push_back(12'h200);
    repeat (9) @(posedge clk);
    @(negedge clk) rst = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) begin
        for (int k = 0; k < 6; k++) hot[k] = 4'($urandom_range(15));
      end
      if ($urandom_range(99) < 70) begin
        addr_queue.push_back({hot[$urandom_range($urandom_range(1) ? 3 : 5)],
                              8'($urandom)});
      end else begin
        addr_queue.push_back(12'($urandom));
      end
    end
    wait (addr_queue.size() == 0 && !in_ch.valid);
    wait (expected_xlate.size() == 0);
    repeat (60) @(posedge clk);
    $display("checked %0d translations: %0d tlb hits, %0d evictions",
             n_checked, n_tlb_hits, n_evictions);
    if (n_errors == 0 && expected_xlate.size() == 0)
      $display("tlb_page_table_lru_translate: match");
    else
      $display("tlb_page_table_lru_translate: mismatch");
    $finish;
  end

endmodule
